[sv/bfdp_pkg.sv]
// Package for the brace frame decimal parser.
// Holds result kind codes, character codes and the result struct; no dependencies.
package bfdp_pkg;

  localparam int unsigned NUM_VALUES = 4;
  // Fields read by the step logic: the header field and one per value
  localparam int unsigned READ_FIELDS = NUM_VALUES + 1;
  localparam int unsigned READ_CHARS  = 3;

  localparam logic [2:0] KIND_VAR   = 3'd0;
  localparam logic [2:0] KIND_UP    = 3'd1;
  localparam logic [2:0] KIND_DN    = 3'd2;
  localparam logic [2:0] KIND_OTHER = 3'd3;
  localparam logic [2:0] KIND_ACK   = 3'd4;

  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_K      = 8'h4b;
  localparam logic [7:0] CH_N      = 8'h4e;
  localparam logic [7:0] CH_O      = 8'h4f;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_U      = 8'h55;
  localparam logic [7:0] CH_V      = 8'h56;

  localparam logic [3:0] ACK_O_SET  = 4'h1;
  localparam logic [3:0] ACK_K_KEEP = 4'hd;
  localparam logic [3:0] ACK_K_SET  = 4'h2;
  localparam logic [3:0] ACK_CR_KEEP = 4'hb;
  localparam logic [3:0] ACK_CR_SET = 4'h4;
  localparam logic [3:0] ACK_LF_KEEP = 4'h7;
  localparam logic [3:0] ACK_LF_SET = 4'h8;
  localparam logic [3:0] ACK_FULL   = 4'hf;

  typedef struct packed {
    logic [2:0]                      kind;
    logic [NUM_VALUES-1:0][7:0]      value;
  } res_t;

endpackage

[sv/brace_frame_decimal_parser.sv]
// Brace frame decimal parser, top level.
// Depends on bfdp_pkg and bfdp_core.
//
// Usage: bytes arrive on the input channel (in_valid_i / in_ready_o, rx_byte_i),
// one request per byte. A '}' always gives one result on the output channel
// (out_valid_o / out_ready_i, result_kind_o, value0_o..value3_o); a completed
// O, K, CR, LF pattern outside a frame gives an ack result. Other bytes give
// no result.
// A taken byte is held in the input register, then stepped into the result
// register, from which its result is shown.
// Throughput: one byte per cycle while the receiver takes results, set by the
// combinational step between the input register and the result register.
// A stalled receiver holds the result register; the input register still
// takes one more byte, then in_ready_o drops until the result is taken.
// Reset clears the frame flags, positions, character store, ack pattern and
// the last decoded values; both channels come up empty.
module brace_frame_decimal_parser import bfdp_pkg::*; #(
  parameter int unsigned NUM_FIELDS      = 5,
  parameter int unsigned CHARS_PER_FIELD = 3
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] result_kind_o,
  output logic [7:0] value0_o,
  output logic [7:0] value1_o,
  output logic [7:0] value2_o,
  output logic [7:0] value3_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  res_t       out_res_q;
  logic       advance;
  logic       res_valid;
  res_t       res;

  // Step the held byte only when the result register can take its result
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  bfdp_core #(
    .NUM_FIELDS     (NUM_FIELDS),
    .CHARS_PER_FIELD(CHARS_PER_FIELD)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .byte_i     (in_byte_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= res_valid;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
    if (advance && res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_res_q.kind;
  assign value0_o      = out_res_q.value[0];
  assign value1_o      = out_res_q.value[1];
  assign value2_o      = out_res_q.value[2];
  assign value3_o      = out_res_q.value[3];

  a_close_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_byte_q == CH_RBRACE |=> out_valid_o)
    else $error("frame close produced no result");

  a_values_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o != KIND_VAR |->
      value0_o == 8'h00 && value1_o == 8'h00 && value2_o == 8'h00 && value3_o == 8'h00)
    else $error("non-value result carries values");

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_byte_q))
    else $error("held byte lost while result register stalled");

endmodule

[sv/bfdp_dec.sv]
// Decimal decoder for one field of up to three ASCII characters.
// Depends on bfdp_pkg for the digit range.
module bfdp_dec import bfdp_pkg::*; (
  input  logic [7:0] c0_i,
  input  logic [7:0] c1_i,
  input  logic [7:0] c2_i,
  input  logic [7:0] prev_i,
  output logic [7:0] value_o
);

  logic [7:0] d0, d1, d2;

  assign d0 = c0_i - CH_ZERO;
  assign d1 = c1_i - CH_ZERO;
  assign d2 = c2_i - CH_ZERO;

  // Arithmetic wraps at 8 bits, leading non-digits included
  always_comb begin
    if (c2_i inside {[CH_ZERO:CH_NINE]}) begin
      value_o = 8'(d0 * 8'd100) + 8'(d1 * 8'd10) + d2;
    end else if (c1_i inside {[CH_ZERO:CH_NINE]}) begin
      value_o = 8'(d0 * 8'd10) + d1;
    end else if (c0_i inside {[CH_ZERO:CH_NINE]}) begin
      value_o = d0;
    end else begin
      value_o = prev_i;
    end
  end

endmodule

[sv/bfdp_core.sv]
// Parser state and per-byte step: frame flags, character store, ack pattern.
// Depends on bfdp_pkg and bfdp_dec.
module bfdp_core import bfdp_pkg::*; #(
  parameter int unsigned NUM_FIELDS      = 5,
  parameter int unsigned CHARS_PER_FIELD = 3
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  localparam int unsigned FPW = $clog2(NUM_FIELDS + 1);
  localparam int unsigned CPW = $clog2(CHARS_PER_FIELD + 1);

  logic           in_frame_q, in_frame_d;
  logic [CPW-1:0] char_pos_q, char_pos_d;
  logic [FPW-1:0] field_pos_q, field_pos_d;
  logic [3:0]     ack_bits_q, ack_bits_d;
  logic [NUM_FIELDS-1:0][CHARS_PER_FIELD-1:0][7:0] store_q, store_d;
  logic [NUM_VALUES-1:0][7:0] last_q, last_d;

  logic [READ_FIELDS-1:0][READ_CHARS-1:0][7:0] slot;
  logic [NUM_VALUES-1:0][7:0] dec_value;
  logic [3:0] ack_next;
  logic       ack_hit;
  logic       hdr_var, hdr_up, hdr_dn;

  // Slots beyond the store read as zero
  for (genvar f = 0; f < READ_FIELDS; f++) begin : g_slot_f
    for (genvar c = 0; c < READ_CHARS; c++) begin : g_slot_c
      if (f < NUM_FIELDS && c < CHARS_PER_FIELD) begin : g_real
        assign slot[f][c] = store_q[f][c];
      end else begin : g_zero
        assign slot[f][c] = 8'h00;
      end
    end
  end

  for (genvar k = 0; k < NUM_VALUES; k++) begin : g_dec
    bfdp_dec u_dec (
      .c0_i   (slot[k+1][0]),
      .c1_i   (slot[k+1][1]),
      .c2_i   (slot[k+1][2]),
      .prev_i (last_q[k]),
      .value_o(dec_value[k])
    );
  end

  assign hdr_var = slot[0][0] == CH_V && slot[0][1] == CH_A && slot[0][2] == CH_R;
  assign hdr_up  = slot[0][0] == CH_U && slot[0][1] == CH_P;
  assign hdr_dn  = slot[0][0] == CH_D && slot[0][1] == CH_N;

  always_comb begin
    ack_hit  = 1'b1;
    ack_next = ack_bits_q;
    case (byte_i)
      CH_O:    ack_next = ACK_O_SET;
      CH_K:    ack_next = (ack_bits_q & ACK_K_KEEP) | ACK_K_SET;
      CH_CR:   ack_next = (ack_bits_q & ACK_CR_KEEP) | ACK_CR_SET;
      CH_LF:   ack_next = (ack_bits_q & ACK_LF_KEEP) | ACK_LF_SET;
      default: ack_hit = 1'b0;
    endcase
  end

  always_comb begin
    in_frame_d  = in_frame_q;
    char_pos_d  = char_pos_q;
    field_pos_d = field_pos_q;
    ack_bits_d  = ack_bits_q;
    store_d     = store_q;
    last_d      = last_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (step_i) begin
      case (byte_i)
        CH_LBRACE: begin
          in_frame_d  = 1'b1;
          char_pos_d  = '0;
          field_pos_d = '0;
          store_d     = '0;
        end
        CH_RBRACE: begin
          in_frame_d  = 1'b0;
          res_valid_o = 1'b1;
          if (hdr_var) begin
            res_o.kind  = KIND_VAR;
            res_o.value = dec_value;
            last_d      = dec_value;
            store_d     = '0;
          end else if (hdr_up) begin
            res_o.kind = KIND_UP;
            store_d    = '0;
          end else if (hdr_dn) begin
            res_o.kind = KIND_DN;
            store_d    = '0;
          end else begin
            res_o.kind = KIND_OTHER;
          end
        end
        CH_COLON, CH_COMMA: begin
          if (field_pos_q < FPW'(NUM_FIELDS)) begin
            field_pos_d = field_pos_q + 1'b1;
          end
          char_pos_d = '0;
        end
        default: begin
          if (in_frame_q) begin
            if (char_pos_q < CPW'(CHARS_PER_FIELD)) begin
              for (int f = 0; f < NUM_FIELDS; f++) begin
                for (int c = 0; c < CHARS_PER_FIELD; c++) begin
                  if (field_pos_q == FPW'(f) && char_pos_q == CPW'(c)) begin
                    store_d[f][c] = byte_i;
                  end
                end
              end
              char_pos_d = char_pos_q + 1'b1;
            end
          end else if (ack_hit) begin
            if (ack_next == ACK_FULL) begin
              ack_bits_d  = '0;
              res_valid_o = 1'b1;
              res_o.kind  = KIND_ACK;
            end else begin
              ack_bits_d = ack_next;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q  <= 1'b0;
      char_pos_q  <= '0;
      field_pos_q <= '0;
      ack_bits_q  <= '0;
      store_q     <= '0;
      last_q      <= '0;
    end else begin
      in_frame_q  <= in_frame_d;
      char_pos_q  <= char_pos_d;
      field_pos_q <= field_pos_d;
      ack_bits_q  <= ack_bits_d;
      store_q     <= store_d;
      last_q      <= last_d;
    end
  end

  a_open_clears_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && byte_i == CH_LBRACE |=> in_frame_q && field_pos_q == '0 && char_pos_q == '0)
    else $error("frame open did not reset positions");

  a_ack_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == KIND_ACK |=> ack_bits_q == '0)
    else $error("ack pattern not cleared after ack result");

  a_pos_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    field_pos_q <= FPW'(NUM_FIELDS) && char_pos_q <= CPW'(CHARS_PER_FIELD))
    else $error("field or char position past its limit");

endmodule
